FILE: sv/skoc_pkg.sv
// Shared constants, codes and control types for the sorted key occurrence counter.
package skoc_pkg;

    // Storage geometry.
    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int IDX_W   = FILL_W + 1;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;
    localparam int REQ_W   = 2;

    // Request codes carried in req_type.
    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_COUNT  = 2'd2
    } t_req;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PROBE = 5'b00010,
        ST_CMP   = 5'b00100,
        ST_NBR   = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic append;
        logic load_key;
        logic init_search;
        logic last_mode;
        logic issue_mid;
        logic issue_nbr;
        logic go_right;
        logic go_left;
        logic save_first;
        logic load_res;
        logic res_zero;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_zero;
        logic range_empty;
        logic eq;
        logic gt;
        logic at_edge;
    } t_stat;

endpackage

FILE: sv/skoc_if.sv
// Valid/ready channel interfaces for request and response words.
interface skoc_req_if import skoc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface skoc_rsp_if import skoc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] match_count;

    modport source (output valid, output match_count, input ready);
    modport sink   (input valid, input match_count, output ready);
endinterface

FILE: sv/sorted_key_occurrence_count_core.sv
// Top level of the sorted key occurrence counter.
// The block keeps up to DEPTH signed 32-bit elements, loaded by append words after a
// clear word, and answers each count word with the number of stored elements equal to
// its key, found by a first-match and a last-match binary search. Clear and append
// words give no response; appends past capacity are dropped and request code 3 is
// ignored. Each probe reads the value memory through its single read port, which has
// registered read data, and then compares; a matching probe also reads its neighbor.
// Each of the two searches takes up to log2(fill)+1 probes. One word is in work at a
// time; a finished count waits in an output register. No clearing pass runs after reset.
module sorted_key_occurrence_count_core import skoc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    skoc_req_if.sink   i_req,
    skoc_rsp_if.source o_rsp
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Control sequencer.
    skoc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Storage and search datapath.
    skoc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_value       (i_req.value),
        .o_stat        (w_stat),
        .o_match_count (o_rsp.match_count)
    );

`ifndef ASSERT_OFF
    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_res |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result loaded over a pending word");

    // The response valid only rises after a result load.
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(w_cmd.load_res))
        else $error("response valid without a result load");

    // A probe is issued only for a non-empty range.
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue_mid |-> !w_stat.range_empty)
        else $error("probe issued over an empty range");

    // An accepted count word stops intake until its search is done.
    a_count_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.req_type == REQ_COUNT)) |=> !i_req.ready)
        else $error("intake open during a count");
`endif

endmodule

FILE: sv/skoc_dp.sv
// Datapath: value memory, fill count, search bounds and result register.
module skoc_dp import skoc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    output t_stat                    o_stat,
    output logic [COUNT_W-1:0]       o_match_count
);

    logic [DATA_W-1:0]       r_mem [DEPTH];
    logic [DATA_W-1:0]       r_rdata;
    logic [FILL_W-1:0]       r_fill;
    logic signed [DATA_W-1:0] r_key;
    logic signed [IDX_W-1:0] r_lo;
    logic signed [IDX_W-1:0] r_hi;
    logic [ADDR_W-1:0]       r_mid;
    logic [ADDR_W-1:0]       r_first;
    logic [COUNT_W-1:0]      r_count;

    logic signed [IDX_W:0]   w_sum;
    logic [ADDR_W-1:0]       w_mid;
    logic [ADDR_W-1:0]       w_nbr;
    logic [ADDR_W-1:0]       w_rd_addr;
    logic                    w_full;
    logic signed [IDX_W-1:0] w_mid_x;
    logic signed [IDX_W-1:0] w_first_x;
    logic signed [IDX_W-1:0] w_span;

    // Midpoint of the current range; the sum is non-negative whenever a probe issues.
    assign w_sum = IDX_W'(r_lo) + IDX_W'(r_hi);
    assign w_mid = w_sum[ADDR_W:1];

    // Neighbor of the last probe: below it for the first match, above it for the last.
    assign w_nbr     = i_cmd.last_mode ? r_mid + ADDR_W'(1) : r_mid - ADDR_W'(1);
    assign w_rd_addr = i_cmd.issue_nbr ? w_nbr : w_mid;
    assign w_full    = (r_fill == FILL_W'(DEPTH));

    assign w_mid_x   = $signed(IDX_W'(r_mid));
    assign w_first_x = $signed(IDX_W'(r_first));
    assign w_span    = w_mid_x - w_first_x + IDX_W'(1);

    // Memory write on append and registered read every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !w_full) begin
            r_mem[r_fill[ADDR_W-1:0]] <= i_value;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.clear) begin
            r_fill <= '0;
        end else if (i_cmd.append && !w_full) begin
            r_fill <= r_fill + FILL_W'(1);
        end
    end

    // Search bounds, probe index, first match and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key <= i_value;
        end
        if (i_cmd.init_search) begin
            r_lo <= '0;
            r_hi <= $signed(IDX_W'(r_fill)) - IDX_W'(1);
        end else if (i_cmd.go_right) begin
            r_lo <= w_mid_x + IDX_W'(1);
        end else if (i_cmd.go_left) begin
            r_hi <= w_mid_x - IDX_W'(1);
        end
        if (i_cmd.issue_mid) begin
            r_mid <= w_mid;
        end
        if (i_cmd.save_first) begin
            r_first <= r_mid;
        end
        if (i_cmd.load_res) begin
            if (i_cmd.res_zero || (w_mid_x < w_first_x)) begin
                r_count <= '0;
            end else begin
                r_count <= COUNT_W'(w_span);
            end
        end
    end

    // Status for the controller.
    always_comb begin
        o_stat.fill_zero   = (r_fill == '0);
        o_stat.range_empty = (r_lo > r_hi);
        o_stat.eq          = ($signed(r_rdata) == r_key);
        o_stat.gt          = (r_key > $signed(r_rdata));
        o_stat.at_edge     = i_cmd.last_mode ? (FILL_W'(r_mid) + FILL_W'(1) == r_fill)
                                             : (r_mid == '0);
    end

    assign o_match_count = r_count;

endmodule

FILE: sv/skoc_ctrl.sv
// Controller: request decode and the two binary-search sequences.
module skoc_ctrl import skoc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [REQ_W-1:0] i_req_type,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  t_stat            i_stat,
    output t_cmd             o_cmd
);

    t_state r_state, n_state;
    logic   r_last, n_last;
    logic   r_zero, n_zero;
    logic   r_out_valid;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        n_zero  = r_zero;
        o_cmd   = '0;
        o_cmd.last_mode = r_last;
        o_cmd.res_zero  = r_zero;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_req_type)
                        REQ_CLEAR:  o_cmd.clear  = 1'b1;
                        REQ_APPEND: o_cmd.append = 1'b1;
                        REQ_COUNT: begin
                            o_cmd.load_key    = 1'b1;
                            o_cmd.init_search = 1'b1;
                            n_last = 1'b0;
                            n_zero = i_stat.fill_zero;
                            n_state = i_stat.fill_zero ? ST_DONE : ST_PROBE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PROBE: begin
                if (i_stat.range_empty) begin
                    // No match in this search: the count is zero.
                    n_zero  = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    o_cmd.issue_mid = 1'b1;
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_stat.eq) begin
                    if (i_stat.at_edge) begin
                        if (!r_last) begin
                            o_cmd.save_first  = 1'b1;
                            o_cmd.init_search = 1'b1;
                            n_last  = 1'b1;
                            n_state = ST_PROBE;
                        end else begin
                            n_zero  = 1'b0;
                            n_state = ST_DONE;
                        end
                    end else begin
                        o_cmd.issue_nbr = 1'b1;
                        n_state = ST_NBR;
                    end
                end else if (i_stat.gt) begin
                    o_cmd.go_right = 1'b1;
                    n_state = ST_PROBE;
                end else begin
                    o_cmd.go_left = 1'b1;
                    n_state = ST_PROBE;
                end
            end
            ST_NBR: begin
                if (!i_stat.eq) begin
                    // The neighbor differs, so the probe is the boundary match.
                    if (!r_last) begin
                        o_cmd.save_first  = 1'b1;
                        o_cmd.init_search = 1'b1;
                        n_last  = 1'b1;
                        n_state = ST_PROBE;
                    end else begin
                        n_zero  = 1'b0;
                        n_state = ST_DONE;
                    end
                end else if (r_last) begin
                    o_cmd.go_right = 1'b1;
                    n_state = ST_PROBE;
                end else begin
                    o_cmd.go_left = 1'b1;
                    n_state = ST_PROBE;
                end
            end
            ST_DONE: begin
                // Load the result once the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_res = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_zero  <= n_zero;
        end
    end

    // Output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: test/sorted_key_occurrence_count_core_test.sv
// Self-checking testbench for the sorted key occurrence counter core.
`timescale 1ns / 100ps

import skoc_pkg::*;

// Tracks the stored array, predicts every count word and checks the responses.
class count_tracker;
    logic signed [DATA_W-1:0] entries [DEPTH];
    int                       fill;
    logic [COUNT_W-1:0]       expected_counts [$];
    int                       errors;
    int                       checked;
    int                       n_clear;
    int                       n_append;
    int                       n_dropped;
    int                       n_count;
    int                       n_unused;
    int                       peak_fill;

    function new();
        fill      = 0;
        errors    = 0;
        checked   = 0;
        n_clear   = 0;
        n_append  = 0;
        n_dropped = 0;
        n_count   = 0;
        n_unused  = 0;
        peak_fill = 0;
    endfunction

    // Lowest index holding the key, as the hardware search finds it, or -1.
    function int find_first(logic signed [DATA_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = fill - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (entries[mid] == key) begin
                if (mid == 0 || entries[mid-1] != key) return mid;
                hi = mid - 1;
            end else if (key > entries[mid]) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return -1;
    endfunction

    // Highest index holding the key; the bound is tested before the next entry is read.
    function int find_last(logic signed [DATA_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = fill - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (entries[mid] == key) begin
                if (mid == fill - 1 || entries[mid+1] != key) return mid;
                lo = mid + 1;
            end else if (key > entries[mid]) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return -1;
    endfunction

    function logic [COUNT_W-1:0] predict_count(logic signed [DATA_W-1:0] key);
        int first;
        int last;
        int cnt;
        cnt = 0;
        if (fill > 0) begin
            first = find_first(key);
            last  = find_last(key);
            if (first >= 0 && last >= first) cnt = last - first + 1;
        end
        return cnt[COUNT_W-1:0];
    endfunction

    // Called for every request word accepted by the block.
    function void note_request(logic [REQ_W-1:0] code, logic signed [DATA_W-1:0] v);
        case (code)
            REQ_CLEAR: begin
                fill = 0;
                n_clear++;
            end
            REQ_APPEND: begin
                n_append++;
                if (fill < DEPTH) begin
                    entries[fill] = v;
                    fill++;
                    if (fill > peak_fill) peak_fill = fill;
                end else begin
                    n_dropped++;
                end
            end
            REQ_COUNT: begin
                n_count++;
                expected_counts.push_back(predict_count(v));
            end
            default: n_unused++;
        endcase
    endfunction

    // Called for every response word accepted from the block.
    function void check_count(logic [COUNT_W-1:0] actual);
        logic [COUNT_W-1:0] want;
        if (expected_counts.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual match_count %0d",
                     $time, actual);
            errors++;
        end else begin
            want = expected_counts.pop_front();
            checked++;
            if (actual !== want) begin
                $display("%0t: match_count mismatch, expected %0d, actual %0d",
                         $time, want, actual);
                errors++;
            end
        end
    endfunction

    function int pending();
        return expected_counts.size();
    endfunction
endclass

module sorted_key_occurrence_count_core_test;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 950;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 100;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic i_clk;
    logic i_rst_n;

    skoc_req_if req_ch ();
    skoc_rsp_if rsp_ch ();

    sorted_key_occurrence_count_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    count_tracker tracker;
    int           sent_items;
    bit           calm;
    int unsigned  idle_cycles;

    // Clock generation.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Gap before a request word: mostly short, now and then long, none when calm.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)   return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Drive one request word at the falling edge and hold it until it is accepted.
    task automatic send(logic [REQ_W-1:0] code, logic signed [DATA_W-1:0] v);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= code;
        req_ch.value    <= v;
        do @(posedge i_clk); while (!req_ch.ready);
        if (code != REQ_UNUSED) sent_items++;
    endtask

    // Hold the sender off until every predicted count has come back.
    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // One load: clear, a run of appends that is non-decreasing unless scrambled, then count words.
    task automatic load_and_query();
        logic signed [DATA_W-1:0] stored [$];
        longint                   cur;
        int                       n;
        int                       k;
        int                       r;
        int                       step;
        logic signed [DATA_W-1:0] key;
        bit                       scramble;

        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150) : $urandom_range(0, 24);
        scramble = ($urandom_range(0, 9) == 0);
        r = $urandom_range(0, 3);
        case (r)
            0: cur = $signed(32'($urandom()));
            1: cur = -64'sd2147483648 + $urandom_range(0, 50);
            2: cur = 64'sd2147483647 - $urandom_range(0, 200);
            default: cur = $signed(32'($urandom_range(0, 40))) - 20;
        endcase

        send(REQ_CLEAR, $signed(32'($urandom())));
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            step = (r < 50) ? 0 : (r < 85) ? $urandom_range(1, 3) : $urandom_range(0, 1 << 20);
            cur = cur + step;
            if (cur > 64'sd2147483647) cur = 64'sd2147483647;
            key = cur[DATA_W-1:0];
            // Out-of-order noise exercises the searches on unsorted contents.
            if (scramble && $urandom_range(0, 3) == 0) key = $signed(32'($urandom()));
            stored.push_back(key);
            send(REQ_APPEND, key);
            if ($urandom_range(0, 19) == 0) send(REQ_UNUSED, $signed(32'($urandom())));
        end

        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++) begin
            r = $urandom_range(0, 99);
            if (stored.size() == 0 || r >= 80) begin
                key = $signed(32'($urandom()));
            end else begin
                key = stored[$urandom_range(0, stored.size() - 1)];
                if (r >= 60) key = ($urandom_range(0, 1) == 0) ? key + 1 : key - 1;
            end
            send(REQ_COUNT, key);
        end
    endtask

    // A burst of arbitrary words, including unused codes.
    task automatic noise_burst();
        logic [REQ_W-1:0] code;
        for (int i = 0; i < 10; i++) begin
            code = REQ_W'($urandom_range(0, 3));
            if (code == REQ_CLEAR && $urandom_range(0, 1) == 0) code = REQ_APPEND;
            send(code, $signed(32'($urandom())));
        end
    endtask

    // Response sink: ready in stretches, stalls mostly short and a few long.
    initial begin
        int len;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 1) == 0) begin
                rsp_ch.ready <= 1'b1;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 30);
            end else begin
                rsp_ch.ready <= 1'b0;
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 3);
            end
            repeat (len - 1) @(negedge i_clk);
        end
    end

    // Monitor both channels at the rising edge and watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                tracker.note_request(req_ch.req_type, req_ch.value);
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_count(rsp_ch.match_count);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d counts outstanding",
                         $time, IDLE_LIMIT, tracker.pending());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        logic signed [DATA_W-1:0] fill_value;
        int                       start;
        tracker         = new();
        sent_items      = 0;
        calm            = 1'b0;
        idle_cycles     = 0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_CLEAR;
        req_ch.value    = '0;
        i_rst_n         = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty array, unused code, extremes, lone matches, runs, unsorted data.
        send(REQ_COUNT, 32'sd0);
        send(REQ_UNUSED, -32'sd1);
        send(REQ_APPEND, VAL_MIN);
        send(REQ_COUNT, VAL_MIN);
        send(REQ_COUNT, VAL_MAX);
        send(REQ_APPEND, VAL_MAX);
        send(REQ_COUNT, VAL_MAX);
        send(REQ_COUNT, VAL_MIN);
        send(REQ_CLEAR, 32'sd0);
        send(REQ_COUNT, VAL_MIN);
        send(REQ_APPEND, 32'sd5);
        send(REQ_APPEND, 32'sd5);
        send(REQ_APPEND, 32'sd5);
        send(REQ_COUNT, 32'sd5);
        send(REQ_APPEND, 32'sd1);
        send(REQ_COUNT, 32'sd1);
        send(REQ_COUNT, 32'sd5);
        send(REQ_CLEAR, VAL_MAX);
        send(REQ_APPEND, -32'sd1);
        send(REQ_APPEND, 32'sd0);
        send(REQ_APPEND, 32'sd0);
        send(REQ_COUNT, 32'sd0);
        send(REQ_COUNT, -32'sd1);
        send(REQ_UNUSED, 32'sd0);
        send(REQ_COUNT, 32'sd7);
        drain();

        // Full array of one value, then appends past capacity that must be dropped.
        calm = 1'b1;
        fill_value = $signed(32'($urandom()));
        send(REQ_CLEAR, 32'sd0);
        for (int i = 0; i < DEPTH; i++) send(REQ_APPEND, fill_value);
        calm = 1'b0;
        send(REQ_COUNT, fill_value);
        for (int i = 0; i < 3; i++) send(REQ_APPEND, fill_value + 1);
        send(REQ_COUNT, fill_value);
        send(REQ_COUNT, fill_value + 1);
        send(REQ_COUNT, fill_value - 1);
        drain();

        // Random loads and queries with some noise in between.
        start = sent_items;
        while (sent_items - start < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) drain();
            if ($urandom_range(0, 99) < 85) load_and_query();
            else                            noise_burst();
        end
        calm = 1'b0;

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (tracker.pending() != 0) begin
            $display("%0t: %0d expected counts never arrived", $time, tracker.pending());
            tracker.errors++;
        end

        $display("Covered %0d clears, %0d appends (%0d dropped at capacity), %0d unused codes.",
                 tracker.n_clear, tracker.n_append, tracker.n_dropped, tracker.n_unused);
        $display("Checked %0d of %0d count responses, peak fill %0d, %0d errors.",
                 tracker.checked, tracker.n_count, tracker.peak_fill, tracker.errors);
        if (tracker.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
